FILE: src/windowed_moving_average_macros.svh
// Assertion macros for the windowed moving average checker.
// Included by the checker file; needs clk and rst in the including scope.
`ifndef WINDOWED_MOVING_AVERAGE_MACROS_SVH
`define WINDOWED_MOVING_AVERAGE_MACROS_SVH

// Same-cycle implication, quiet while in reset
`define WMA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("wma check failed");

// Next-cycle implication, quiet while in reset
`define WMA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("wma check failed");

// Next-cycle implication that also holds through reset
`define WMA_ASSERT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("wma check failed");

`endif

FILE: src/wma_pkg.sv
// Shared constants and types for the windowed moving average.
// No dependencies; used by every module of the block.
package wma_pkg;

  localparam int DATA_W             = 32;  // sample and mean width
  localparam int CNT_W              = 5;   // held count and window length width
  localparam int DEFAULT_MAX_WINDOW = 16;
  localparam int OUT_TDATA_W        = 40;  // mean + count, padded to bytes
  localparam int ITER_W             = $clog2(DATA_W + 1);

  localparam logic [CNT_W-1:0] LEN_RESET = CNT_W'(16);

  // request kinds carried on s_tuser
  localparam logic REQ_PUSH  = 1'b0;
  localparam logic REQ_CLEAR = 1'b1;

  // control broadcast to every cell of the sample chain
  typedef struct packed {
    logic             shift;      // move the chain one step toward cell 0
    logic [CNT_W-1:0] entry_idx;  // cell that takes the new sample
  } cell_ctl_t;

endpackage

FILE: src/windowed_moving_average.sv
// Windowed moving average: a chain of sample cells, running sum and serial divider.
// Top level of the block; depends on wma_pkg, wma_cell and wma_divider.
//
// Input channel s_*: s_tuser selects push (0) or clear (1), s_tdata carries the
// 32-bit sample. Output channel m_*: m_tdata holds the truncated mean of the held
// samples and the held count. One result per transfer in.
// cfg_we/cfg_wdata set the window length (0 acts as 1, above MAX_WINDOW acts as
// MAX_WINDOW); a write also empties the window.
// Samples sit in a row of MAX_WINDOW cells; a push enters at the window's far
// cell and the whole row moves one step, so the dropped sample is always in cell 0.
// The result comes from the 32-step radix-2 divider. One item is in flight at a
// time; s_tready returns in the cycle the result is loaded into the output
// register. A finished result waits in the output register while the next
// item is accepted; a stalled receiver holds the divider result until m_tready.
// Reset empties the window, sets the length to 16 and drops any pending result.
module windowed_moving_average #(
  parameter int MAX_WINDOW = wma_pkg::DEFAULT_MAX_WINDOW
) (
  input  logic                            clk,
  input  logic                            rst,
  // s_tdata: [31:0] sample
  input  logic [wma_pkg::DATA_W-1:0]      s_tdata,
  // s_tuser: [0] req_type
  input  logic                            s_tuser,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // m_tdata: [31:0] mean_value, [36:32] held_count, [39:37] zero
  output logic [wma_pkg::OUT_TDATA_W-1:0] m_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic                            cfg_we,
  input  logic [wma_pkg::CNT_W-1:0]       cfg_wdata
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_HOLD
  } state_t;

  state_t                        state;
  logic [wma_pkg::CNT_W-1:0]     window_length;
  logic [wma_pkg::CNT_W-1:0]     eff_len;
  logic [wma_pkg::CNT_W-1:0]     fill_count;
  logic [wma_pkg::CNT_W-1:0]     fill_count_next;
  logic [wma_pkg::DATA_W-1:0]    running_sum;
  logic [wma_pkg::DATA_W-1:0]    running_sum_next;
  logic [wma_pkg::DATA_W-1:0]    dropped;
  logic                          in_xfer;
  logic                          is_push;
  logic                          full;
  logic                          out_free;
  logic                          out_load;
  logic                          div_done;
  logic [wma_pkg::DATA_W-1:0]    quotient;
  logic [wma_pkg::DATA_W-1:0]    mean_value;
  wma_pkg::cell_ctl_t            cell_ctl;
  logic [wma_pkg::DATA_W-1:0]    cell_data [MAX_WINDOW];

  assign s_tready = (state == ST_IDLE);
  assign in_xfer  = s_tvalid && s_tready;
  assign is_push  = (s_tuser == wma_pkg::REQ_PUSH);
  assign out_free = !m_tvalid || m_tready;

  // window length in use, saturated to 1..MAX_WINDOW
  always_comb begin
    if (window_length == '0) begin
      eff_len = wma_pkg::CNT_W'(1);
    end else if (32'(window_length) > MAX_WINDOW) begin
      eff_len = wma_pkg::CNT_W'(MAX_WINDOW);
    end else begin
      eff_len = window_length;
    end
  end

  assign full = (fill_count == eff_len);

  // sample chain: new sample enters at cell eff_len-1, oldest leaves from cell 0
  assign cell_ctl.shift     = in_xfer && is_push;
  assign cell_ctl.entry_idx = eff_len - 1'b1;

  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    if (i == MAX_WINDOW - 1) begin : g_last
      wma_cell #(.IDX(i)) u_cell (
        .clk       (clk),
        .ctl       (cell_ctl),
        .sample_in (s_tdata),
        .next_data (s_tdata),
        .data      (cell_data[i])
      );
    end else begin : g_mid
      wma_cell #(.IDX(i)) u_cell (
        .clk       (clk),
        .ctl       (cell_ctl),
        .sample_in (s_tdata),
        .next_data (cell_data[i+1]),
        .data      (cell_data[i])
      );
    end
  end

  // running sum and fill count for the accepted item
  assign dropped = full ? cell_data[0] : '0;

  always_comb begin
    if (is_push) begin
      running_sum_next = running_sum - dropped + s_tdata;
      fill_count_next  = full ? fill_count : fill_count + 1'b1;
    end else begin
      running_sum_next = '0;
      fill_count_next  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= wma_pkg::LEN_RESET;
      fill_count    <= '0;
      running_sum   <= '0;
    end else if (cfg_we) begin
      window_length <= cfg_wdata;
      fill_count    <= '0;
      running_sum   <= '0;
    end else if (in_xfer) begin
      fill_count  <= fill_count_next;
      running_sum <= running_sum_next;
    end
  end

  // mean = sum / count, one bit per cycle
  wma_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (in_xfer),
    .dividend (running_sum_next),
    .divisor  (fill_count_next),
    .done     (div_done),
    .quotient (quotient)
  );

  // an empty window averages to zero
  assign mean_value = (fill_count == '0) ? '0 : quotient;

  // finished result moves into the output register once it is free
  assign out_load = ((state == ST_DIV && div_done) || state == ST_HOLD) && out_free;

  // sequencing and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
        m_tdata  <= {{(wma_pkg::OUT_TDATA_W - wma_pkg::DATA_W - wma_pkg::CNT_W){1'b0}},
                     fill_count, mean_value};
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_xfer) begin
            state <= ST_DIV;
          end
        end
        ST_DIV, ST_HOLD: begin
          if (out_load) begin
            state <= ST_IDLE;
          end else if (div_done) begin
            state <= ST_HOLD;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: src/wma_cell.sv
// One storage cell of the sample chain.
// Depends on wma_pkg for the data width and the chain control struct.
module wma_cell #(
  parameter int IDX = 0
) (
  input  logic                       clk,
  input  wma_pkg::cell_ctl_t         ctl,
  input  logic [wma_pkg::DATA_W-1:0] sample_in,
  input  logic [wma_pkg::DATA_W-1:0] next_data,
  output logic [wma_pkg::DATA_W-1:0] data
);

  logic is_entry;

  // the cell at the window's far end loads the new sample, others take their neighbor
  assign is_entry = (32'(ctl.entry_idx) == IDX);

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      data <= is_entry ? sample_in : next_data;
    end
  end

endmodule

FILE: src/wma_divider.sv
// Radix-2 restoring divider: 32-bit dividend by a small unsigned count.
// Depends on wma_pkg for widths; one quotient bit per cycle.
module wma_divider (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [wma_pkg::DATA_W-1:0] dividend,
  input  logic [wma_pkg::CNT_W-1:0]  divisor,
  output logic                       done,
  output logic [wma_pkg::DATA_W-1:0] quotient
);

  logic [wma_pkg::CNT_W-1:0]  divisor_q;
  logic [wma_pkg::CNT_W-1:0]  rem;
  logic [wma_pkg::ITER_W-1:0] iter;
  logic                       running;
  logic [wma_pkg::CNT_W:0]    trial;
  logic [wma_pkg::CNT_W:0]    diff;
  logic                       ge;

  // shift one dividend bit into the partial remainder and try a subtract
  assign trial = {rem, quotient[wma_pkg::DATA_W-1]};
  assign diff  = trial - {1'b0, divisor_q};
  assign ge    = (trial >= {1'b0, divisor_q});

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      iter    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        iter    <= '0;
      end else if (running) begin
        iter <= iter + 1'b1;
        if (iter == wma_pkg::ITER_W'(wma_pkg::DATA_W - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // datapath: quotient bits shift in as dividend bits shift out
  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend;
      divisor_q <= divisor;
      rem       <= '0;
    end else if (running) begin
      quotient <= {quotient[wma_pkg::DATA_W-2:0], ge};
      rem      <= ge ? diff[wma_pkg::CNT_W-1:0] : trial[wma_pkg::CNT_W-1:0];
    end
  end

endmodule

FILE: src/wma_checker.sv
// Port-level checks for windowed_moving_average, attached by bind.
// Depends on windowed_moving_average_macros.svh and wma_pkg.
`include "windowed_moving_average_macros.svh"

module wma_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic [wma_pkg::OUT_TDATA_W-1:0] m_tdata,
  input logic                            m_tvalid,
  input logic                            m_tready
);

  // a stalled result keeps its value
  `WMA_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

  // one item in flight: no transfer in right after one was taken
  `WMA_ASSERT_NEXT(a_busy_after_in, s_tvalid && s_tready, !s_tready)

  // an empty window always reports a zero mean
  `WMA_ASSERT_NOW(a_empty_zero, m_tvalid && (m_tdata[36:32] == 5'd0), m_tdata[31:0] == 32'd0)

  // reset drops any pending result
  `WMA_ASSERT_ALWAYS(a_rst_clear, rst, !m_tvalid)

endmodule

bind windowed_moving_average wma_checker u_wma_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tdata  (m_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready)
);
